// ----- rtl/plc_pkg.sv -----
// ============================================================================
// plc_pkg
// shared widths, register indexes and helpers for the level calibration block
// ============================================================================
package plc_pkg;

    // raw code width as seen at the ports and in the anchor registers
    localparam int RAW_W    = 28;
    // number of raw code bits actually used (8 to 32)
    localparam int RAW_BITS = 28;
    // working raw width: the used bits that the ports can carry
    localparam int RW       = (RAW_BITS < RAW_W) ? RAW_BITS : RAW_W;

    localparam int PCT_W    = 7;               // saturated percent, 0 to 100
    localparam int FRAC_W   = 8;               // Q7.8 fraction bits
    localparam int QW       = PCT_W + FRAC_W;  // result width, also quotient width
    localparam int XW       = RW + QW;         // dividend width
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int NUM_ANCHORS = 4;

    localparam logic [7:0]       PCT_MAX   = 8'd100;
    localparam logic [CFG_W-1:0] PCT_RESET = 32'h6449_2900;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_RAW_0 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_RAW_1 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RAW_2 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RAW_3 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PCT   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CAL   = 3'd5;

    typedef logic [RW-1:0]    raw_t;
    typedef logic [PCT_W-1:0] pct_t;
    typedef logic [QW-1:0]    q8_t;

    // per-request control that rides alongside the divider
    typedef struct packed {
        logic interp;   // result is base +/- quotient
        logic neg;      // falling percent across the segment
        logic uncal;    // block not calibrated
        q8_t  base;     // anchor percent in Q7.8 (or clamp value)
    } side_t;

    function automatic pct_t sat_pct(input logic [7:0] b);
        pct_t p;
        if (b > PCT_MAX)
        begin
            p = PCT_MAX[PCT_W-1:0];
        end
        else
        begin
            p = b[PCT_W-1:0];
        end
        return p;
    endfunction

endpackage

// ----- rtl/piecewise_linear_level_calibration.sv -----
// ============================================================================
// piecewise_linear_level_calibration
// raw level code to fill percent (Q7.8) over four calibration anchors
// ============================================================================
//
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall raw_code
//  level     out        level_valid/level_stall   percent_q8, uncalibrated
//  config    in         cfg_we                    cfg_index, cfg_data
//
//  one request per cycle while the level output is not stalled; a result reaches
//  the level port through 19 register stages
//  (segment compare, operand select, multiply, 15 divider stages, output)
//  the divider pipeline, one quotient bit per stage, sets the latency
//  a stalled output freezes the whole pipeline; one skid register takes the
//  request in flight, so sample_stall is a register output
//  reset is asynchronous, clears valid bits and loads the configuration reset
//  values; no clearing pass
//
module piecewise_linear_level_calibration (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [plc_pkg::RAW_W-1:0]     raw_code,
    output logic                          level_valid,
    input  logic                          level_stall,
    output logic [plc_pkg::QW-1:0]        percent_q8,
    output logic                          uncalibrated,
    input  logic                          cfg_we,
    input  logic [plc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [plc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int RW     = plc_pkg::RW;
    localparam int RAW_W  = plc_pkg::RAW_W;
    localparam int PCT_W  = plc_pkg::PCT_W;
    localparam int FRAC_W = plc_pkg::FRAC_W;
    localparam int NA     = plc_pkg::NUM_ANCHORS;

    // configuration
    logic [RAW_W-1:0]           raw_anchor_reg [NA];
    logic [plc_pkg::CFG_W-1:0]  pct_anchors_reg;
    logic                       calibrated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NA; k++)
            begin
                raw_anchor_reg[k] <= '0;
            end
            pct_anchors_reg <= plc_pkg::PCT_RESET;
            calibrated_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plc_pkg::CFG_RAW_0: raw_anchor_reg[0] <= cfg_data[RAW_W-1:0];
                plc_pkg::CFG_RAW_1: raw_anchor_reg[1] <= cfg_data[RAW_W-1:0];
                plc_pkg::CFG_RAW_2: raw_anchor_reg[2] <= cfg_data[RAW_W-1:0];
                plc_pkg::CFG_RAW_3: raw_anchor_reg[3] <= cfg_data[RAW_W-1:0];
                plc_pkg::CFG_PCT:   pct_anchors_reg   <= cfg_data;
                plc_pkg::CFG_CAL:   calibrated_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    plc_pkg::raw_t anchor [NA];
    plc_pkg::pct_t pct    [NA];

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            anchor[k] = raw_anchor_reg[k][RW-1:0];
            pct[k]    = plc_pkg::sat_pct(pct_anchors_reg[8*k +: 8]);
        end
    end

    // pipeline advance and input skid
    logic          pipe_en;
    logic          skid_valid_reg;
    plc_pkg::raw_t skid_raw_reg;
    logic          src_valid;
    plc_pkg::raw_t src_raw;

    assign pipe_en      = !(level_valid && level_stall);
    assign sample_stall = skid_valid_reg;
    assign src_valid    = skid_valid_reg || sample_valid;
    assign src_raw      = skid_valid_reg ? skid_raw_reg : raw_code[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (sample_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pipe_en && !skid_valid_reg)
        begin
            skid_raw_reg <= raw_code[RW-1:0];
        end
    end

    // stage 1: segment bracket tests
    logic [NA-2:0] seg_ne;
    logic [NA-2:0] seg_rise;
    logic [NA-2:0] seg_hit;
    logic          s1_hit_next;
    logic [1:0]    s1_seg_next;
    logic          s1_first_next;

    always_comb
    begin
        for (int i = 0; i < NA - 1; i++)
        begin
            seg_ne[i]   = (anchor[i] != anchor[i+1]);
            seg_rise[i] = (anchor[i] < anchor[i+1]);
            seg_hit[i]  = seg_ne[i] &&
                          (seg_rise[i] ? (src_raw >= anchor[i] && src_raw <= anchor[i+1])
                                       : (src_raw <= anchor[i] && src_raw >= anchor[i+1]));
        end
        s1_hit_next = |seg_hit;
        priority if (seg_hit[0])
        begin
            s1_seg_next = 2'd0;
        end
        else if (seg_hit[1])
        begin
            s1_seg_next = 2'd1;
        end
        else
        begin
            s1_seg_next = 2'd2;
        end
        // out of range: pick the end that the overall polarity puts below or above
        if (anchor[0] < anchor[NA-1])
        begin
            s1_first_next = (src_raw < anchor[0]);
        end
        else
        begin
            s1_first_next = (src_raw > anchor[0]);
        end
    end

    logic          s1_valid_reg;
    plc_pkg::raw_t s1_raw_reg;
    logic          s1_hit_reg;
    logic [1:0]    s1_seg_reg;
    logic          s1_first_reg;
    logic          s1_uncal_reg;

    // stage 2: operand select
    plc_pkg::raw_t  r0;
    plc_pkg::raw_t  r1;
    plc_pkg::pct_t  p0;
    plc_pkg::pct_t  p1;
    plc_pkg::raw_t  s2_num_next;
    plc_pkg::raw_t  s2_den_next;
    plc_pkg::pct_t  s2_delta_next;
    plc_pkg::side_t s2_side_next;
    plc_pkg::pct_t  clamp_pct;

    always_comb
    begin
        unique case (s1_seg_reg)
            2'd0:
            begin
                r0 = anchor[0];
                r1 = anchor[1];
                p0 = pct[0];
                p1 = pct[1];
            end
            2'd1:
            begin
                r0 = anchor[1];
                r1 = anchor[2];
                p0 = pct[1];
                p1 = pct[2];
            end
            default:
            begin
                r0 = anchor[2];
                r1 = anchor[3];
                p0 = pct[2];
                p1 = pct[3];
            end
        endcase
        if (r0 < r1)
        begin
            s2_num_next = s1_raw_reg - r0;
            s2_den_next = r1 - r0;
        end
        else
        begin
            s2_num_next = r0 - s1_raw_reg;
            s2_den_next = r0 - r1;
        end
        s2_side_next.neg = (p1 < p0);
        s2_delta_next    = s2_side_next.neg ? (p0 - p1) : (p1 - p0);
        clamp_pct        = s1_first_reg ? pct[0] : pct[NA-1];
        s2_side_next.interp = s1_hit_reg;
        s2_side_next.uncal  = s1_uncal_reg;
        s2_side_next.base   = s1_hit_reg ? {p0, {FRAC_W{1'b0}}}
                                         : {clamp_pct, {FRAC_W{1'b0}}};
    end

    logic           s2_valid_reg;
    plc_pkg::raw_t  s2_num_reg;
    plc_pkg::raw_t  s2_den_reg;
    plc_pkg::pct_t  s2_delta_reg;
    plc_pkg::side_t s2_side_reg;

    // stage 3: numerator times percent span
    logic [RW+PCT_W-1:0]    prod;
    logic                   s3_valid_reg;
    logic [plc_pkg::XW-1:0] s3_x_reg;
    plc_pkg::raw_t          s3_den_reg;
    plc_pkg::side_t         s3_side_reg;

    assign prod = s2_num_reg * s2_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_raw_reg   <= src_raw;
            s1_hit_reg   <= s1_hit_next;
            s1_seg_reg   <= s1_seg_next;
            s1_first_reg <= s1_first_next;
            s1_uncal_reg <= !calibrated_reg;
            s2_num_reg   <= s2_num_next;
            s2_den_reg   <= s2_den_next;
            s2_delta_reg <= s2_delta_next;
            s2_side_reg  <= s2_side_next;
            s3_x_reg     <= {prod, {FRAC_W{1'b0}}};
            s3_den_reg   <= s2_den_reg;
            s3_side_reg  <= s2_side_reg;
        end
    end

    // divider
    logic           div_valid;
    plc_pkg::q8_t   div_q;
    plc_pkg::side_t div_side;

    plc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_x_reg),
        .divisor   (s3_den_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .quotient  (div_q),
        .out_side  (div_side)
    );

    // output stage
    plc_pkg::q8_t result_next;
    logic         level_valid_reg;
    plc_pkg::q8_t percent_reg;
    logic         uncal_reg;

    always_comb
    begin
        priority if (div_side.uncal)
        begin
            result_next = '0;
        end
        else if (!div_side.interp)
        begin
            result_next = div_side.base;
        end
        else if (div_side.neg)
        begin
            result_next = div_side.base - div_q;
        end
        else
        begin
            result_next = div_side.base + div_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            level_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            percent_reg <= result_next;
            uncal_reg   <= div_side.uncal;
        end
    end

    assign level_valid  = level_valid_reg;
    assign percent_q8   = percent_reg;
    assign uncalibrated = uncal_reg;

    // checks
    a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && uncalibrated |-> percent_q8 == '0)
        else $error("uncalibrated result with nonzero percent");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid |-> percent_q8 <= 15'd25600)
        else $error("percent above one hundred");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(sample_valid && level_valid && level_stall))
        else $error("skid filled without a stalled output");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && div_side.interp && !div_side.uncal && !div_side.neg
        |-> {1'b0, div_side.base} + {1'b0, div_q} <= 16'd25600)
        else $error("interpolated value overshoots");

endmodule

// ----- rtl/plc_div.sv -----
// ============================================================================
// plc_div
// pipelined restoring divider, one quotient bit per stage
// ============================================================================
module plc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [plc_pkg::XW-1:0] dividend,
    input  plc_pkg::raw_t        divisor,
    input  plc_pkg::side_t       in_side,
    output logic                 out_valid,
    output plc_pkg::q8_t         quotient,
    output plc_pkg::side_t       out_side
);

    localparam int QW = plc_pkg::QW;
    localparam int RW = plc_pkg::RW;

    logic                 v_reg    [QW];
    plc_pkg::raw_t        r_reg    [QW];
    plc_pkg::q8_t         x_reg    [QW];
    plc_pkg::q8_t         q_reg    [QW];
    plc_pkg::raw_t        den_reg  [QW];
    plc_pkg::side_t       side_reg [QW];

    logic                 st_v     [QW];
    plc_pkg::raw_t        st_r     [QW];
    plc_pkg::q8_t         st_x     [QW];
    plc_pkg::q8_t         st_q     [QW];
    plc_pkg::raw_t        st_den   [QW];
    plc_pkg::side_t       st_side  [QW];

    logic [RW:0]          trial    [QW];
    logic [RW:0]          diff     [QW];
    logic                 ge       [QW];

    plc_pkg::raw_t        r_next   [QW];
    plc_pkg::q8_t         x_next   [QW];
    plc_pkg::q8_t         q_next   [QW];

    // stage inputs: first stage from the ports, the rest from the previous stage
    always_comb
    begin
        st_v[0]    = in_valid;
        st_r[0]    = dividend[plc_pkg::XW-1:QW];
        st_x[0]    = dividend[QW-1:0];
        st_q[0]    = '0;
        st_den[0]  = divisor;
        st_side[0] = in_side;
        for (int s = 1; s < QW; s++)
        begin
            st_v[s]    = v_reg[s-1];
            st_r[s]    = r_reg[s-1];
            st_x[s]    = x_reg[s-1];
            st_q[s]    = q_reg[s-1];
            st_den[s]  = den_reg[s-1];
            st_side[s] = side_reg[s-1];
        end
    end

    // partial remainder stays below the divisor
    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            trial[s]  = {st_r[s], st_x[s][QW-1]};
            diff[s]   = trial[s] - {1'b0, st_den[s]};
            ge[s]     = (trial[s] >= {1'b0, st_den[s]});
            r_next[s] = ge[s] ? diff[s][RW-1:0] : trial[s][RW-1:0];
            x_next[s] = {st_x[s][QW-2:0], 1'b0};
            q_next[s] = {st_q[s][QW-2:0], ge[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < QW; s++)
            begin
                v_reg[s] <= st_v[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QW; s++)
            begin
                r_reg[s]    <= r_next[s];
                x_reg[s]    <= x_next[s];
                q_reg[s]    <= q_next[s];
                den_reg[s]  <= st_den[s];
                side_reg[s] <= st_side[s];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quotient  = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- verif/level_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// level_checker
// watches the sample, level and config ports of the level calibration block,
// predicts each fill level from a shadow copy of the anchors and compares it
// field by field with what comes out of the level channel, in order
// ============================================================================
module level_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  logic                          sample_stall,
    input  logic [plc_pkg::RAW_W-1:0]     raw_code,
    input  logic                          level_valid,
    input  logic                          level_stall,
    input  logic [plc_pkg::QW-1:0]        percent_q8,
    input  logic                          uncalibrated,
    input  logic                          cfg_we,
    input  logic [plc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [plc_pkg::CFG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam int RAW_W = plc_pkg::RAW_W;
    localparam int QW    = plc_pkg::QW;
    localparam int NA    = plc_pkg::NUM_ANCHORS;

    typedef struct packed {
        logic [QW-1:0] level_q8;
        logic          uncal;
    } level_t;

    logic [RAW_W-1:0]          anchor_raw [NA];
    logic [plc_pkg::CFG_W-1:0] pct_word;
    logic                      cal_en;
    level_t                    expected_levels [$];
    level_t                    oldest;

    function automatic logic [63:0] saturated_pct(input int k);
        logic [7:0] b;
        b = pct_word[8*k +: 8];
        if (b > 8'd100)
        begin
            b = 8'd100;
        end
        return {56'd0, b};
    endfunction

    function automatic level_t predict_level(input logic [RAW_W-1:0] code);
        logic [63:0] m;
        logic [63:0] raw;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] res;
        logic [63:0] a0;
        logic [63:0] a3;
        logic        found;
        logic        first;
        level_t      lv;
        int          k;
        m = (64'd1 << plc_pkg::RAW_BITS) - 64'd1;
        raw = {36'd0, code} & m;
        res = '0;
        num = '0;
        den = 64'd1;
        found = 1'b0;
        if (!cal_en)
        begin
            lv.level_q8 = '0;
            lv.uncal = 1'b1;
            return lv;
        end
        for (k = 0; k < NA - 1; k++)
        begin
            r0 = {36'd0, anchor_raw[k]} & m;
            r1 = {36'd0, anchor_raw[k+1]} & m;
            p0 = saturated_pct(k);
            p1 = saturated_pct(k + 1);
            // equal raw codes make an empty segment
            if (!found && r0 != r1)
            begin
                if (r0 < r1 && raw >= r0 && raw <= r1)
                begin
                    num = raw - r0;
                    den = r1 - r0;
                    found = 1'b1;
                end
                else if (r0 > r1 && raw <= r0 && raw >= r1)
                begin
                    num = r0 - raw;
                    den = r0 - r1;
                    found = 1'b1;
                end
                if (found)
                begin
                    if (p1 >= p0)
                    begin
                        res = p0 * 256 + (num * ((p1 - p0) * 256)) / den;
                    end
                    else
                    begin
                        res = p0 * 256 - (num * ((p0 - p1) * 256)) / den;
                    end
                end
            end
        end
        if (!found)
        begin
            // clamp side follows the overall polarity of the curve
            a0 = {36'd0, anchor_raw[0]} & m;
            a3 = {36'd0, anchor_raw[NA-1]} & m;
            if (a0 < a3)
            begin
                first = raw < a0;
            end
            else
            begin
                first = raw > a0;
            end
            res = (first ? saturated_pct(0) : saturated_pct(NA - 1)) * 256;
        end
        lv.level_q8 = res[QW-1:0];
        lv.uncal = 1'b0;
        return lv;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NA; k++)
            begin
                anchor_raw[k] = '0;
            end
            pct_word = plc_pkg::PCT_RESET;
            cal_en = 1'b0;
            expected_levels.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_levels.push_back(predict_level(raw_code));
            end
            if (level_valid && !level_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("level result with no request outstanding: percent_q8 %0d",
                           percent_q8);
                    errors++;
                end
                else
                begin
                    oldest = expected_levels.pop_front();
                    if (percent_q8 !== oldest.level_q8)
                    begin
                        $error("percent_q8 mismatch: expected %0d actual %0d",
                               oldest.level_q8, percent_q8);
                        errors++;
                    end
                    if (uncalibrated !== oldest.uncal)
                    begin
                        $error("uncalibrated mismatch: expected %0d actual %0d",
                               oldest.uncal, uncalibrated);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    plc_pkg::CFG_RAW_0: anchor_raw[0] = cfg_data[RAW_W-1:0];
                    plc_pkg::CFG_RAW_1: anchor_raw[1] = cfg_data[RAW_W-1:0];
                    plc_pkg::CFG_RAW_2: anchor_raw[2] = cfg_data[RAW_W-1:0];
                    plc_pkg::CFG_RAW_3: anchor_raw[3] = cfg_data[RAW_W-1:0];
                    plc_pkg::CFG_PCT:   pct_word = cfg_data;
                    plc_pkg::CFG_CAL:   cal_en = cfg_data[0];
                    default:            ;
                endcase
            end
            pending = expected_levels.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// stimulus for the level calibration block: directed anchor curves, then
// random calibrations and codes under three sender/receiver idling mixes
// ============================================================================
module tb;

    localparam int RAW_W       = plc_pkg::RAW_W;
    localparam int QW          = plc_pkg::QW;
    localparam int IDX_W       = plc_pkg::IDX_W;
    localparam int CFG_W       = plc_pkg::CFG_W;
    localparam int NA          = plc_pkg::NUM_ANCHORS;

    localparam int LATENCY     = 19;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETS        = 4;
    localparam int PER_SET     = 119;

    // indexes past the last register, writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    typedef enum int {
        CURVE_RISING,
        CURVE_FALLING,
        CURVE_SCRAMBLED,
        CURVE_FLAT_SEGMENT,
        CURVE_FULL_SCALE
    } curve_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    logic [RAW_W-1:0] raw_code = '0;
    logic             level_valid;
    logic             level_stall = 1'b0;
    logic [QW-1:0]    percent_q8;
    logic             uncalibrated;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    int               errors;
    int               pending;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               cycles = 0;
    logic [RAW_W-1:0] cur_anchor [NA];

    piecewise_linear_level_calibration DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .raw_code     (raw_code),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .percent_q8   (percent_q8),
        .uncalibrated (uncalibrated),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    level_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .raw_code     (raw_code),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .percent_q8   (percent_q8),
        .uncalibrated (uncalibrated),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        level_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] code);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_valid = 1'b0;
            raw_code = RAW_W'($urandom);
            @(negedge clk);
        end
        sample_valid = 1'b1;
        raw_code = code;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
    endtask

    // every request yields a level, so an empty queue means an empty pipeline
    task automatic wait_idle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = d;
    endtask

    task automatic apply_calibration(input logic [RAW_W-1:0] a0, input logic [RAW_W-1:0] a1,
                                     input logic [RAW_W-1:0] a2, input logic [RAW_W-1:0] a3,
                                     input logic [CFG_W-1:0] pcts, input logic cal);
        wait_idle();
        cur_anchor[0] = a0;
        cur_anchor[1] = a1;
        cur_anchor[2] = a2;
        cur_anchor[3] = a3;
        // upper data bits above the anchor width are junk and must be dropped
        write_reg(plc_pkg::CFG_RAW_0, {4'($urandom), a0});
        write_reg(plc_pkg::CFG_RAW_1, {4'($urandom), a1});
        write_reg(plc_pkg::CFG_RAW_2, {4'($urandom), a2});
        write_reg(plc_pkg::CFG_RAW_3, {4'($urandom), a3});
        write_reg(plc_pkg::CFG_PCT, pcts);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        write_reg(plc_pkg::CFG_CAL, {31'($urandom), cal});
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_pcts();
        logic [CFG_W-1:0] w;
        for (int k = 0; k < NA; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w[8*k +: 8] = 8'($urandom_range(101, 255));
            end
            else
            begin
                w[8*k +: 8] = 8'($urandom_range(0, 100));
            end
        end
        return w;
    endfunction

    task automatic random_calibration(input curve_t curve, input logic cal);
        logic [RAW_W-1:0] v [NA];
        logic [RAW_W-1:0] t;
        logic [RAW_W-1:0] base;
        int               scale;
        int               j;
        scale = $urandom_range(0, 2);
        base = RAW_W'($urandom);
        for (int k = 0; k < NA; k++)
        begin
            case (scale)
                0:       v[k] = base + RAW_W'($urandom_range(0, 1000));
                1:       v[k] = RAW_W'($urandom_range(0, 1 << 20));
                default: v[k] = RAW_W'($urandom);
            endcase
        end
        for (int a = 0; a < NA - 1; a++)
        begin
            for (int b = 0; b < NA - 1 - a; b++)
            begin
                if ((curve == CURVE_RISING && v[b] > v[b+1]) ||
                    (curve == CURVE_FALLING && v[b] < v[b+1]))
                begin
                    t = v[b];
                    v[b] = v[b+1];
                    v[b+1] = t;
                end
            end
        end
        if (curve == CURVE_FLAT_SEGMENT)
        begin
            j = $urandom_range(0, NA - 2);
            v[j+1] = v[j];
        end
        else if (curve == CURVE_FULL_SCALE)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                v[0] = '0;
                v[3] = RAW_MAX;
            end
            else
            begin
                v[0] = RAW_MAX;
                v[3] = '0;
            end
        end
        apply_calibration(v[0], v[1], v[2], v[3], random_pcts(), cal);
    endtask

    // most codes land inside the curve or right at a segment boundary
    function automatic logic [RAW_W-1:0] pick_code();
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
        logic [RAW_W-1:0] pick;
        int               mode;
        int               k;
        lo = cur_anchor[0];
        hi = cur_anchor[0];
        for (k = 1; k < NA; k++)
        begin
            if (cur_anchor[k] < lo)
            begin
                lo = cur_anchor[k];
            end
            if (cur_anchor[k] > hi)
            begin
                hi = cur_anchor[k];
            end
        end
        mode = $urandom_range(0, 9);
        k = $urandom_range(0, NA - 1);
        if (mode < 4)
        begin
            pick = RAW_W'($urandom_range(hi, lo));
        end
        else if (mode < 6)
        begin
            pick = cur_anchor[k] + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
        end
        else if (mode < 8)
        begin
            pick = cur_anchor[k] + RAW_W'($urandom_range(0, 200)) - RAW_W'(100);
        end
        else
        begin
            pick = RAW_W'($urandom);
        end
        return pick;
    endfunction

    initial
    begin
        int drain;
        cur_anchor[0] = '0;
        cur_anchor[1] = '0;
        cur_anchor[2] = '0;
        cur_anchor[3] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out of reset the block is not calibrated
        send_sample('0);
        send_sample(RAW_MAX);

        // calibrated with the reset anchors: every segment empty, all clamped
        wait_idle();
        write_reg(plc_pkg::CFG_CAL, 32'd1);
        @(negedge clk);
        cfg_we = 1'b0;
        send_sample('0);
        send_sample(28'd5);

        apply_calibration(28'd100, 28'd1000, 28'd5000, RAW_MAX, plc_pkg::PCT_RESET, 1'b1);
        send_sample('0);
        send_sample(28'd100);
        send_sample(28'd550);
        send_sample(28'd1000);
        send_sample(28'd3000);
        send_sample(28'd5000);
        send_sample(28'h800_0000);
        send_sample(RAW_MAX);

        // falling codes, an empty middle segment and percents above one hundred
        apply_calibration(RAW_MAX, 28'd200000, 28'd200000, '0, 32'h0032_80FF, 1'b1);
        send_sample('0);
        send_sample(RAW_MAX);
        send_sample(28'd100000);
        send_sample(28'd200000);
        send_sample(28'h123_4567);

        // zig-zag curve with codes outside every segment on both sides
        apply_calibration(28'd500, 28'd100, 28'd900, 28'd300, 32'h3C14_5A0A, 1'b1);
        send_sample(28'd50);
        send_sample(28'd950);
        send_sample(28'd700);

        apply_calibration(28'd7, 28'd7, 28'd7, 28'd7, 32'hFFFF_FFFF, 1'b1);
        send_sample(28'd7);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 88;
                end
                1:
                begin
                    tx_idle_pct = 88;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SETS; s++)
            begin
                random_calibration(curve_t'($urandom_range(0, 4)),
                                   $urandom_range(0, 7) != 0);
                for (int n = 0; n < PER_SET; n++)
                begin
                    send_sample(pick_code());
                end
            end
        end

        @(negedge clk);
        sample_valid = 1'b0;
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (LATENCY + 8) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
